@@ rtl/core/rqi_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rqi_pkg: shared types and constants for the ray / quad intersection unit
// Fixed-point formats, configuration register codes and the beat payloads.
// ----------------------------------------------------------------------------
package rqi_pkg;

    // Component width of coordinates, normals and w vectors
    localparam int COORD_W     = 20;
    localparam int PACK_W      = 3 * COORD_W;
    localparam int T_W         = 32;
    localparam int UV_W        = 17;
    localparam int CFG_DATA_W  = PACK_W;
    localparam int CFG_INDEX_W = 3;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_CORNER = 3'd0,
        CFG_U_EDGE = 3'd1,
        CFG_V_EDGE = 3'd2,
        CFG_NORMAL = 3'd3,
        CFG_OFFSET = 3'd4,
        CFG_W_VEC  = 3'd5
    } cfg_index_t;

    // One ray beat
    typedef struct packed {
        logic signed [COORD_W-1:0] origin_x;
        logic signed [COORD_W-1:0] origin_y;
        logic signed [COORD_W-1:0] origin_z;
        logic signed [COORD_W-1:0] dir_x;
        logic signed [COORD_W-1:0] dir_y;
        logic signed [COORD_W-1:0] dir_z;
        logic signed [T_W-1:0]     t_min;
        logic signed [T_W-1:0]     t_max;
    } rqi_in_t;

    // One result beat
    typedef struct packed {
        logic                      is_hit;
        logic signed [T_W-1:0]     hit_t;
        logic [UV_W-1:0]           coord_u;
        logic [UV_W-1:0]           coord_v;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
        logic                      front_face;
    } rqi_out_t;

endpackage

@@ rtl/core/ray_quad_intersection.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_quad_intersection: pipelined ray / parallelogram hit test
// Tests each ray against the configured parallelogram and reports t, the
// plane coordinates, the hit point and the front-face flag.
// ----------------------------------------------------------------------------
// Usage:
//   Write the six shape registers through cfg_wr_en / cfg_index / cfg_data
//   while no ray is in flight; software precomputes normal, offset and w.
//   Rays enter on in_valid / in_stall, one beat per ray, and each ray gives
//   exactly one result beat on out_valid / out_stall, in order. A miss
//   carries is_hit low and all other fields zero.
//   Three stages form the dot products and magnitudes, one stage checks
//   quotient overflow, 32 stages form the quotient of t one bit each, seven
//   stages test t and form the hit point, the cross products and the w
//   weighted terms, and the output register takes the plane coordinates.
//   One ray per cycle while out_stall is low; the bit-per-stage divider sets depth.
//   Every stage holds only when it is full and the stage after it holds, so
//   bubbles close up and a stalled receiver backs the pipeline up one stage
//   at a time; in_stall rises only once the first stage is full and held.
//   Reset clears all valid bits and the shape registers to zero.
// ----------------------------------------------------------------------------
module ray_quad_intersection
    import rqi_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  rqi_in_t                in_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output rqi_out_t               out_data
);

    localparam int W    = COORD_W;
    localparam int QW   = T_W;
    localparam int PRW  = 2 * W;
    localparam int DW   = 2 * W + 2;
    localparam int NW   = ((DW > 42) ? DW : 42) + 1;
    localparam int CW   = (NW > DW + 16) ? NW : DW + 16;
    localparam int TXW  = QW + 1;
    localparam int TDW  = QW + W;
    localparam int PW   = W + 17;
    localparam int RW   = W + 18;
    localparam int RCW  = W + 1;
    localparam int CPW  = 2 * W + 1;
    localparam int CRW  = 2 * W + 2;
    localparam int SW   = CRW - 6;
    localparam int WSW  = W + SW;
    localparam int AW   = WSW + 2;
    localparam int UV_SHIFT = 12;

    localparam logic signed [RW-1:0] R_LIM    = RW'(1) << W;
    localparam logic signed [PW-1:0] P_MAX    = PW'((1 << (W - 1)) - 1);
    localparam logic signed [PW-1:0] P_MIN    = -P_MAX - PW'(1);
    localparam logic signed [AW-1:0] UNIT_ONE = AW'(1) << 28;
    localparam logic [QW-1:0]        Q_NEG_MAX = {1'b1, {(QW-1){1'b0}}};

    // Cyclic neighbours for cross products
    localparam int NX [3] = '{1, 2, 0};
    localparam int PV [3] = '{2, 0, 1};

    typedef struct packed {
        logic [2:0][W-1:0] o;
        logic [2:0][W-1:0] d;
        logic [QW-1:0]     tmin;
        logic [QW-1:0]     tmax;
    } ray_t;

    typedef struct packed {
        ray_t ray;
        logic front;
        logic qneg;
        logic bad;
    } div_side_t;

    // ------------------------------------------------------------------
    // Shape registers
    // ------------------------------------------------------------------
    logic [PACK_W-1:0]     cfg_corner_reg;
    logic [PACK_W-1:0]     cfg_u_reg;
    logic [PACK_W-1:0]     cfg_v_reg;
    logic [PACK_W-1:0]     cfg_n_reg;
    logic signed [QW-1:0]  cfg_offset_reg;
    logic [PACK_W-1:0]     cfg_w_reg;

    // Take a register write; unknown indexes drop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_corner_reg <= '0;
            cfg_u_reg      <= '0;
            cfg_v_reg      <= '0;
            cfg_n_reg      <= '0;
            cfg_offset_reg <= '0;
            cfg_w_reg      <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_CORNER: cfg_corner_reg <= cfg_data;
                CFG_U_EDGE: cfg_u_reg      <= cfg_data;
                CFG_V_EDGE: cfg_v_reg      <= cfg_data;
                CFG_NORMAL: cfg_n_reg      <= cfg_data;
                CFG_OFFSET: cfg_offset_reg <= cfg_data[QW-1:0];
                CFG_W_VEC:  cfg_w_reg      <= cfg_data;
                default:    ;
            endcase
        end
    end

    logic signed [W-1:0] cq [3];
    logic signed [W-1:0] cu [3];
    logic signed [W-1:0] cv [3];
    logic signed [W-1:0] cn [3];
    logic signed [W-1:0] cw [3];

    // Unpack the vector registers, x lowest
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            cq[i] = $signed(cfg_corner_reg[i*W +: W]);
            cu[i] = $signed(cfg_u_reg[i*W +: W]);
            cv[i] = $signed(cfg_v_reg[i*W +: W]);
            cn[i] = $signed(cfg_n_reg[i*W +: W]);
            cw[i] = $signed(cfg_w_reg[i*W +: W]);
        end
    end

    // ------------------------------------------------------------------
    // Stage advance chain
    // ------------------------------------------------------------------
    logic adv1, adv2, adv3, adv5, adv6, adv7, adv8, adv9, adv10, adv11, adv_out;
    logic dv_adv [0:QW];

    logic s1_v_reg, s2_v_reg, s3_v_reg, s5_v_reg, s6_v_reg, s7_v_reg;
    logic s8_v_reg, s9_v_reg, s10_v_reg, s11_v_reg, out_v_reg;
    logic dv_v_reg [0:QW];

    assign adv_out = !out_v_reg || !out_stall;
    assign adv11   = !s11_v_reg || adv_out;
    assign adv10   = !s10_v_reg || adv11;
    assign adv9    = !s9_v_reg  || adv10;
    assign adv8    = !s8_v_reg  || adv9;
    assign adv7    = !s7_v_reg  || adv8;
    assign adv6    = !s6_v_reg  || adv7;
    assign adv5    = !s5_v_reg  || adv6;
    assign dv_adv[QW] = !dv_v_reg[QW] || adv5;
    assign adv3    = !s3_v_reg  || dv_adv[0];
    assign adv2    = !s2_v_reg  || adv3;
    assign adv1    = !s1_v_reg  || adv2;
    assign in_stall = !adv1;

    // ------------------------------------------------------------------
    // Stage 1: normal products with direction and origin
    // ------------------------------------------------------------------
    ray_t                  ray_in;
    logic signed [PRW-1:0] nd_next [3];
    logic signed [PRW-1:0] no_next [3];
    ray_t                  s1_ray_reg;
    logic signed [PRW-1:0] s1_nd_reg [3];
    logic signed [PRW-1:0] s1_no_reg [3];

    always_comb
    begin
        ray_in.o[0] = in_data.origin_x;
        ray_in.o[1] = in_data.origin_y;
        ray_in.o[2] = in_data.origin_z;
        ray_in.d[0] = in_data.dir_x;
        ray_in.d[1] = in_data.dir_y;
        ray_in.d[2] = in_data.dir_z;
        ray_in.tmin = in_data.t_min;
        ray_in.tmax = in_data.t_max;
        for (int i = 0; i < 3; i++)
        begin
            nd_next[i] = PRW'(cn[i]) * PRW'($signed(ray_in.d[i]));
            no_next[i] = PRW'(cn[i]) * PRW'($signed(ray_in.o[i]));
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: denominator and numerator sums
    // ------------------------------------------------------------------
    logic signed [DW-1:0] den_next;
    logic signed [NW-1:0] num_next;
    ray_t                 s2_ray_reg;
    logic signed [DW-1:0] s2_den_reg;
    logic signed [NW-1:0] s2_num_reg;

    always_comb
    begin
        den_next = DW'(s1_nd_reg[0]) + DW'(s1_nd_reg[1]) + DW'(s1_nd_reg[2]);
        num_next = (NW'(cfg_offset_reg) <<< 10) - NW'(s1_no_reg[0])
                   - NW'(s1_no_reg[1]) - NW'(s1_no_reg[2]);
    end

    // ------------------------------------------------------------------
    // Stage 3: magnitudes and signs
    // ------------------------------------------------------------------
    logic [DW-1:0] den_mag_next;
    logic [NW-1:0] num_mag_next;
    ray_t          s3_ray_reg;
    logic [DW-1:0] s3_den_reg;
    logic [NW-1:0] s3_num_reg;
    logic          s3_zero_reg, s3_front_reg, s3_qneg_reg;

    always_comb
    begin
        den_mag_next = (s2_den_reg < 0) ? DW'(-s2_den_reg) : DW'(s2_den_reg);
        num_mag_next = (s2_num_reg < 0) ? NW'(-s2_num_reg) : NW'(s2_num_reg);
    end

    // ------------------------------------------------------------------
    // Stage 4 (divider entry): overflow check and initial remainder
    // ------------------------------------------------------------------
    logic [DW-1:0]    dv_rem_reg  [0:QW];
    logic [DW-1:0]    dv_den_reg  [0:QW];
    logic [QW-1:0]    dv_qd_reg   [0:QW];
    div_side_t        dv_side_reg [0:QW];
    logic             ovf_next;
    div_side_t        side0_next;

    always_comb
    begin
        ovf_next = CW'(s3_num_reg) >= CW'({s3_den_reg, 16'h0000});
        side0_next.ray   = s3_ray_reg;
        side0_next.front = s3_front_reg;
        side0_next.qneg  = s3_qneg_reg;
        side0_next.bad   = s3_zero_reg || ovf_next;
    end

    // Advance the valid bits of the front stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg    <= 1'b0;
            s2_v_reg    <= 1'b0;
            s3_v_reg    <= 1'b0;
            dv_v_reg[0] <= 1'b0;
        end
        else
        begin
            if (adv1)
                s1_v_reg <= in_valid;
            if (adv2)
                s2_v_reg <= s1_v_reg;
            if (adv3)
                s3_v_reg <= s2_v_reg;
            if (dv_adv[0])
                dv_v_reg[0] <= s3_v_reg;
        end
    end

    // Advance the payload of the front stages
    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            s1_ray_reg <= ray_in;
            s1_nd_reg  <= nd_next;
            s1_no_reg  <= no_next;
        end
        if (adv2)
        begin
            s2_ray_reg <= s1_ray_reg;
            s2_den_reg <= den_next;
            s2_num_reg <= num_next;
        end
        if (adv3)
        begin
            s3_ray_reg   <= s2_ray_reg;
            s3_den_reg   <= den_mag_next;
            s3_num_reg   <= num_mag_next;
            s3_zero_reg  <= (s2_den_reg == 0);
            s3_front_reg <= (s2_den_reg < 0);
            s3_qneg_reg  <= (s2_num_reg < 0) ^ (s2_den_reg < 0);
        end
        if (dv_adv[0])
        begin
            dv_rem_reg[0]  <= DW'(s3_num_reg >> 16);
            dv_den_reg[0]  <= s3_den_reg;
            dv_qd_reg[0]   <= {s3_num_reg[15:0], 16'h0000};
            dv_side_reg[0] <= side0_next;
        end
    end

    // ------------------------------------------------------------------
    // Divider: one quotient bit per stage, restoring
    // ------------------------------------------------------------------
    for (genvar k = 0; k < QW; k++)
    begin : g_div
        logic [DW:0]   rem2;
        logic          ge;
        logic [DW-1:0] rem_next;

        assign dv_adv[k] = !dv_v_reg[k] || dv_adv[k+1];

        // Shift in the next dividend bit and trial-subtract
        always_comb
        begin
            rem2     = {dv_rem_reg[k], dv_qd_reg[k][QW-1]};
            ge       = rem2 >= {1'b0, dv_den_reg[k]};
            rem_next = ge ? DW'(rem2 - {1'b0, dv_den_reg[k]}) : DW'(rem2);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_v_reg[k+1] <= 1'b0;
            else if (dv_adv[k+1])
                dv_v_reg[k+1] <= dv_v_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (dv_adv[k+1])
            begin
                dv_rem_reg[k+1]  <= rem_next;
                dv_den_reg[k+1]  <= dv_den_reg[k];
                dv_qd_reg[k+1]   <= {dv_qd_reg[k][QW-2:0], ge};
                dv_side_reg[k+1] <= dv_side_reg[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: signed t, range and interval test
    // ------------------------------------------------------------------
    div_side_t             dq_side;
    logic [QW-1:0]         dq_mag;
    logic signed [TXW-1:0] t_ext;
    logic signed [TXW-1:0] tmin_ext, tmax_ext;
    logic                  t_fit, hit5_next;
    ray_t                  s5_ray_reg;
    logic signed [QW-1:0]  s5_t_reg;
    logic                  s5_hit_reg, s5_front_reg;

    always_comb
    begin
        dq_side  = dv_side_reg[QW];
        dq_mag   = dv_qd_reg[QW];
        t_ext    = dq_side.qneg ? -$signed({1'b0, dq_mag}) : $signed({1'b0, dq_mag});
        tmin_ext = TXW'($signed(dq_side.ray.tmin));
        tmax_ext = TXW'($signed(dq_side.ray.tmax));
        t_fit    = dq_side.qneg ? (dq_mag <= Q_NEG_MAX) : !dq_mag[QW-1];
        hit5_next = !dq_side.bad && t_fit && (t_ext >= tmin_ext) && (t_ext <= tmax_ext);
    end

    // ------------------------------------------------------------------
    // Stage 6: t times direction
    // ------------------------------------------------------------------
    logic signed [TDW-1:0] td_next [3];
    ray_t                  s6_ray_reg;
    logic signed [TDW-1:0] s6_td_reg [3];
    logic signed [QW-1:0]  s6_t_reg;
    logic                  s6_hit_reg, s6_front_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            td_next[i] = TDW'(s5_t_reg) * TDW'($signed(s5_ray_reg.d[i]));
    end

    // ------------------------------------------------------------------
    // Stage 7: hit point
    // ------------------------------------------------------------------
    logic signed [PW-1:0] p_next [3];
    logic signed [PW-1:0] s7_p_reg [3];
    logic signed [QW-1:0] s7_t_reg;
    logic                 s7_hit_reg, s7_front_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            p_next[i] = PW'($signed(s6_ray_reg.o[i])) + PW'(s6_td_reg[i] >>> 16);
    end

    // ------------------------------------------------------------------
    // Stage 8: offset from corner, far check, point saturation
    // ------------------------------------------------------------------
    logic signed [RW-1:0]  r_full [3];
    logic signed [RCW-1:0] r_next [3];
    logic signed [W-1:0]   psat_next [3];
    logic                  far_next;
    logic signed [RCW-1:0] s8_r_reg [3];
    logic signed [W-1:0]   s8_p_reg [3];
    logic signed [QW-1:0]  s8_t_reg;
    logic                  s8_hit_reg, s8_front_reg;

    always_comb
    begin
        far_next = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            r_full[i] = RW'(s7_p_reg[i]) - RW'(cq[i]);
            r_next[i] = RCW'(r_full[i]);
            if (r_full[i] >= R_LIM || r_full[i] <= -R_LIM)
                far_next = 1'b1;
            if (s7_p_reg[i] > P_MAX)
                psat_next[i] = W'(P_MAX);
            else if (s7_p_reg[i] < P_MIN)
                psat_next[i] = W'(P_MIN);
            else
                psat_next[i] = W'(s7_p_reg[i]);
        end
    end

    // ------------------------------------------------------------------
    // Stage 9: cross product terms
    // ------------------------------------------------------------------
    logic signed [CPW-1:0] ap_next [3];
    logic signed [CPW-1:0] an_next [3];
    logic signed [CPW-1:0] bp_next [3];
    logic signed [CPW-1:0] bn_next [3];
    logic signed [CPW-1:0] s9_ap_reg [3];
    logic signed [CPW-1:0] s9_an_reg [3];
    logic signed [CPW-1:0] s9_bp_reg [3];
    logic signed [CPW-1:0] s9_bn_reg [3];
    logic signed [W-1:0]   s9_p_reg [3];
    logic signed [QW-1:0]  s9_t_reg;
    logic                  s9_hit_reg, s9_front_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ap_next[i] = CPW'(s8_r_reg[NX[i]]) * CPW'(cv[PV[i]]);
            an_next[i] = CPW'(s8_r_reg[PV[i]]) * CPW'(cv[NX[i]]);
            bp_next[i] = CPW'(cu[NX[i]]) * CPW'(s8_r_reg[PV[i]]);
            bn_next[i] = CPW'(cu[PV[i]]) * CPW'(s8_r_reg[NX[i]]);
        end
    end

    // ------------------------------------------------------------------
    // Stage 10: cross products, drop six fraction bits
    // ------------------------------------------------------------------
    logic signed [CRW-1:0] ca [3];
    logic signed [CRW-1:0] cb [3];
    logic signed [SW-1:0]  sa_next [3];
    logic signed [SW-1:0]  sb_next [3];
    logic signed [SW-1:0]  s10_sa_reg [3];
    logic signed [SW-1:0]  s10_sb_reg [3];
    logic signed [W-1:0]   s10_p_reg [3];
    logic signed [QW-1:0]  s10_t_reg;
    logic                  s10_hit_reg, s10_front_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ca[i] = CRW'(s9_ap_reg[i]) - CRW'(s9_an_reg[i]);
            cb[i] = CRW'(s9_bp_reg[i]) - CRW'(s9_bn_reg[i]);
            sa_next[i] = SW'(ca[i] >>> 6);
            sb_next[i] = SW'(cb[i] >>> 6);
        end
    end

    // ------------------------------------------------------------------
    // Stage 11: weight by w
    // ------------------------------------------------------------------
    logic signed [WSW-1:0] wa_next [3];
    logic signed [WSW-1:0] wb_next [3];
    logic signed [WSW-1:0] s11_wa_reg [3];
    logic signed [WSW-1:0] s11_wb_reg [3];
    logic signed [W-1:0]   s11_p_reg [3];
    logic signed [QW-1:0]  s11_t_reg;
    logic                  s11_hit_reg, s11_front_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            wa_next[i] = WSW'(cw[i]) * WSW'(s10_sa_reg[i]);
            wb_next[i] = WSW'(cw[i]) * WSW'(s10_sb_reg[i]);
        end
    end

    // ------------------------------------------------------------------
    // Stage 12: plane coordinates, unit test, result beat
    // ------------------------------------------------------------------
    logic signed [AW-1:0] alpha, beta;
    logic                 hit_final;
    rqi_out_t             res_next;
    rqi_out_t             out_data_reg;

    always_comb
    begin
        alpha = AW'(s11_wa_reg[0]) + AW'(s11_wa_reg[1]) + AW'(s11_wa_reg[2]);
        beta  = AW'(s11_wb_reg[0]) + AW'(s11_wb_reg[1]) + AW'(s11_wb_reg[2]);
        hit_final = s11_hit_reg && (alpha >= 0) && (alpha <= UNIT_ONE)
                    && (beta >= 0) && (beta <= UNIT_ONE);
        res_next = '0;
        if (hit_final)
        begin
            res_next.is_hit     = 1'b1;
            res_next.hit_t      = s11_t_reg;
            res_next.coord_u    = alpha[UV_SHIFT +: UV_W];
            res_next.coord_v    = beta[UV_SHIFT +: UV_W];
            res_next.point_x    = s11_p_reg[0];
            res_next.point_y    = s11_p_reg[1];
            res_next.point_z    = s11_p_reg[2];
            res_next.front_face = s11_front_reg;
        end
    end

    // Advance the valid bits of the back stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_v_reg  <= 1'b0;
            s6_v_reg  <= 1'b0;
            s7_v_reg  <= 1'b0;
            s8_v_reg  <= 1'b0;
            s9_v_reg  <= 1'b0;
            s10_v_reg <= 1'b0;
            s11_v_reg <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (adv5)
                s5_v_reg <= dv_v_reg[QW];
            if (adv6)
                s6_v_reg <= s5_v_reg;
            if (adv7)
                s7_v_reg <= s6_v_reg;
            if (adv8)
                s8_v_reg <= s7_v_reg;
            if (adv9)
                s9_v_reg <= s8_v_reg;
            if (adv10)
                s10_v_reg <= s9_v_reg;
            if (adv11)
                s11_v_reg <= s10_v_reg;
            if (adv_out)
                out_v_reg <= s11_v_reg;
        end
    end

    // Advance the payload of the back stages
    always_ff @(posedge clk)
    begin
        if (adv5)
        begin
            s5_ray_reg   <= dq_side.ray;
            s5_t_reg     <= t_ext[QW-1:0];
            s5_hit_reg   <= hit5_next;
            s5_front_reg <= dq_side.front;
        end
        if (adv6)
        begin
            s6_ray_reg   <= s5_ray_reg;
            s6_td_reg    <= td_next;
            s6_t_reg     <= s5_t_reg;
            s6_hit_reg   <= s5_hit_reg;
            s6_front_reg <= s5_front_reg;
        end
        if (adv7)
        begin
            s7_p_reg     <= p_next;
            s7_t_reg     <= s6_t_reg;
            s7_hit_reg   <= s6_hit_reg;
            s7_front_reg <= s6_front_reg;
        end
        if (adv8)
        begin
            s8_r_reg     <= r_next;
            s8_p_reg     <= psat_next;
            s8_t_reg     <= s7_t_reg;
            s8_hit_reg   <= s7_hit_reg && !far_next;
            s8_front_reg <= s7_front_reg;
        end
        if (adv9)
        begin
            s9_ap_reg    <= ap_next;
            s9_an_reg    <= an_next;
            s9_bp_reg    <= bp_next;
            s9_bn_reg    <= bn_next;
            s9_p_reg     <= s8_p_reg;
            s9_t_reg     <= s8_t_reg;
            s9_hit_reg   <= s8_hit_reg;
            s9_front_reg <= s8_front_reg;
        end
        if (adv10)
        begin
            s10_sa_reg    <= sa_next;
            s10_sb_reg    <= sb_next;
            s10_p_reg     <= s9_p_reg;
            s10_t_reg     <= s9_t_reg;
            s10_hit_reg   <= s9_hit_reg;
            s10_front_reg <= s9_front_reg;
        end
        if (adv11)
        begin
            s11_wa_reg    <= wa_next;
            s11_wb_reg    <= wb_next;
            s11_p_reg     <= s10_p_reg;
            s11_t_reg     <= s10_t_reg;
            s11_hit_reg   <= s10_hit_reg;
            s11_front_reg <= s10_front_reg;
        end
        if (adv_out)
            out_data_reg <= res_next;
    end

    assign out_valid = out_v_reg;
    assign out_data  = out_data_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    // A miss carries nothing but zeros
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.is_hit |->
            out_data.hit_t == 0 && out_data.coord_u == 0 && out_data.coord_v == 0
            && out_data.point_x == 0 && out_data.point_y == 0
            && out_data.point_z == 0 && !out_data.front_face)
        else $error("miss beat carries non-zero fields");

    // Plane coordinates of a hit stay within the unit interval
    a_uv_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.is_hit |->
            out_data.coord_u <= UV_W'(65536) && out_data.coord_v <= UV_W'(65536))
        else $error("plane coordinate beyond one");

    // Final remainder stays below the divisor when the quotient is in range
    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        dv_v_reg[QW] && !dv_side_reg[QW].bad |-> dv_rem_reg[QW] < dv_den_reg[QW])
        else $error("divider remainder not below divisor");

    // A full stage 5 that cannot advance holds its valid bit
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        s5_v_reg && !adv6 |=> s5_v_reg)
        else $error("stalled stage lost its beat");

endmodule
